/* design/bmpq_pkg.sv */
// shared types and codes for the bucket min priority queue
package bmpq_pkg;

   localparam int ID_W   = 16;
   localparam int KEY_W  = 8;
   localparam int OKEY_W = 7;

   localparam logic [2:0] KIND_INSERT   = 3'd0;
   localparam logic [2:0] KIND_EXTRACT  = 3'd1;
   localparam logic [2:0] KIND_PEEK     = 3'd2;
   localparam logic [2:0] KIND_DECREASE = 3'd3;
   localparam logic [2:0] KIND_CLEAR    = 3'd4;

   typedef enum logic [2:0] {
      OP_INSERT,
      OP_EXTRACT,
      OP_PEEK,
      OP_DECREASE,
      OP_CLEAR,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type            op;
      logic              key_ok;
      logic [ID_W-1:0]   item_id;
      logic [KEY_W-1:0]  item_key;
   } cmd_type;

   typedef struct packed {
      logic              ok;
      logic [ID_W-1:0]   out_id;
      logic [OKEY_W-1:0] out_key;
      logic              now_empty;
   } rsp_type;

endpackage

/* design/bucket_min_priority_queue.sv */
// Bucket min priority queue, one FIFO bucket of ids per key.
// Operation transactions go in through req_push / req_full with req_kind, req_item_id
// and req_item_key: insert, extract min, peek min, decrease key, clear. Each one gives
// exactly one result transaction, in order, on rsp_ok, rsp_out_id, rsp_out_key and
// rsp_now_empty, shown while rsp_empty is low and taken with rsp_pop.
// A two-entry command queue feeds the execution engine and a two-entry result queue
// follows it, so new operations are taken while results wait to be popped.
// Clear and operations refused at decode answer straight from the idle state; insert
// passes through S_INS, and extract and peek through S_MIN_SLOT and S_MIN_DONE.
// One operation runs at a time, and the engine takes no new one while its last result
// is still on its way into the result queue. Decrease key walks the buckets upward
// for the id, reading and comparing each slot of a non-empty bucket in turn, then
// moves the later slots down one at a time to close the gap.
// Reset empties every bucket at once through per-bucket valid bits; no clearing pass
// is needed and both queues come up empty. If rsp_pop stays low, the result queue
// fills, the engine stops before starting the next operation, and req_full rises
// once the command queue holds two operations.
module bucket_min_priority_queue #(
   parameter int MAX_KEY         = 127,
   parameter int BUCKET_CAPACITY = 256,
   parameter int ID_BITS         = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [2:0]                  req_kind,
   input  logic [bmpq_pkg::ID_W-1:0]   req_item_id,
   input  logic [bmpq_pkg::KEY_W-1:0]  req_item_key,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic                        rsp_ok,
   output logic [bmpq_pkg::ID_W-1:0]   rsp_out_id,
   output logic [bmpq_pkg::OKEY_W-1:0] rsp_out_key,
   output logic                        rsp_now_empty
);

   logic                                 cmd_valid, cmd_take;
   bmpq_pkg::cmd_type                    cmd;
   logic                                 eng_push, rsp_q_full;
   bmpq_pkg::rsp_type                    eng_rsp, head_rsp;
   logic [$bits(bmpq_pkg::rsp_type)-1:0] rsp_q_out;

   bmpq_front #(
      .MAX_KEY(MAX_KEY)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_kind    (req_kind),
      .req_item_id (req_item_id),
      .req_item_key(req_item_key),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_take    (cmd_take)
   );

   bmpq_engine #(
      .MAX_KEY        (MAX_KEY),
      .BUCKET_CAPACITY(BUCKET_CAPACITY),
      .ID_BITS        (ID_BITS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(cmd_valid),
      .cmd      (cmd),
      .cmd_take (cmd_take),
      .rsp_full (rsp_q_full),
      .rsp_push (eng_push),
      .rsp      (eng_rsp)
   );

   bmpq_fifo #(
      .WIDTH($bits(bmpq_pkg::rsp_type)),
      .DEPTH(2)
   ) u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .push     (eng_push),
      .push_data(eng_rsp),
      .full     (rsp_q_full),
      .pop      (rsp_pop),
      .pop_data (rsp_q_out),
      .empty    (rsp_empty)
   );

   assign head_rsp      = bmpq_pkg::rsp_type'(rsp_q_out);
   assign rsp_ok        = head_rsp.ok;
   assign rsp_out_id    = head_rsp.out_id;
   assign rsp_out_key   = head_rsp.out_key;
   assign rsp_now_empty = head_rsp.now_empty;

endmodule

/* design/bmpq_ram.sv */
// generic single write port ram with registered read
module bmpq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* design/bmpq_fifo.sv */
// small register queue, used for the command and result queues
module bmpq_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/bmpq_front.sv */
// front end: accepts operation transactions, decodes them and queues them
module bmpq_front #(
   parameter int MAX_KEY = 127
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [2:0]                 req_kind,
   input  logic [bmpq_pkg::ID_W-1:0]  req_item_id,
   input  logic [bmpq_pkg::KEY_W-1:0] req_item_key,
   output logic                       cmd_valid,
   output bmpq_pkg::cmd_type          cmd,
   input  logic                       cmd_take
);

   bmpq_pkg::cmd_type                 dec;
   logic [$bits(bmpq_pkg::cmd_type)-1:0] q_out;
   logic                              q_empty;

   always_comb begin
      dec.item_id  = req_item_id;
      dec.item_key = req_item_key;
      dec.key_ok   = (32'(req_item_key) <= 32'(MAX_KEY));
      case (req_kind)
         bmpq_pkg::KIND_INSERT:   dec.op = bmpq_pkg::OP_INSERT;
         bmpq_pkg::KIND_EXTRACT:  dec.op = bmpq_pkg::OP_EXTRACT;
         bmpq_pkg::KIND_PEEK:     dec.op = bmpq_pkg::OP_PEEK;
         bmpq_pkg::KIND_DECREASE: dec.op = bmpq_pkg::OP_DECREASE;
         bmpq_pkg::KIND_CLEAR:    dec.op = bmpq_pkg::OP_CLEAR;
         default:                 dec.op = bmpq_pkg::OP_NOP;
      endcase
   end

   bmpq_fifo #(
      .WIDTH($bits(bmpq_pkg::cmd_type)),
      .DEPTH(2)
   ) u_cmd_q (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_data(dec),
      .full     (req_full),
      .pop      (cmd_take),
      .pop_data (q_out),
      .empty    (q_empty)
   );

   assign cmd       = bmpq_pkg::cmd_type'(q_out);
   assign cmd_valid = !q_empty;

endmodule

/* design/bmpq_engine.sv */
// back end: carries out queue operations on the bucket and slot memories
module bmpq_engine #(
   parameter int MAX_KEY         = 127,
   parameter int BUCKET_CAPACITY = 256,
   parameter int ID_BITS         = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  bmpq_pkg::cmd_type cmd,
   output logic              cmd_take,
   input  logic              rsp_full,
   output logic              rsp_push,
   output bmpq_pkg::rsp_type rsp
);

   localparam int NB  = MAX_KEY + 1;
   localparam int KB  = $clog2(NB);
   localparam int CAP = BUCKET_CAPACITY;
   localparam int HB  = $clog2(CAP);
   localparam int CB  = $clog2(CAP + 1);
   localparam int SD  = NB * CAP;
   localparam int SA  = $clog2(SD);
   localparam int TW  = $clog2(SD + 1);
   localparam int IW  = (ID_BITS < bmpq_pkg::ID_W) ? ID_BITS : bmpq_pkg::ID_W;
   localparam int MW  = HB + CB;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS,
      S_MIN_SLOT,
      S_MIN_DONE,
      S_DK_BKT,
      S_DK_META,
      S_DK_RD,
      S_DK_CMP,
      S_SH_RD,
      S_SH_WR,
      S_DK_PLACE,
      S_DK_TGT,
      S_DK_FIX
   } state_type;

   state_type         state_ff, state_in;
   logic [KB-1:0]     b_ff, b_in;
   logic [KB-1:0]     key_ff, key_in;
   logic [IW-1:0]     id_ff, id_in;
   logic [HB-1:0]     head_ff, head_in;
   logic [CB-1:0]     cnt_ff, cnt_in;
   logic [CB-1:0]     i_ff, i_in;
   logic              ext_ff, ext_in;
   logic [NB-1:0]     vld_ff, vld_in;
   logic [NB-1:0]     ne_ff, ne_in;
   logic [TW-1:0]     total_ff, total_in;
   logic              rsp_push_ff, rsp_push_in;
   bmpq_pkg::rsp_type rsp_ff, rsp_in;
   logic              meta_rvld_ff;

   logic              meta_we;
   logic [KB-1:0]     meta_waddr, meta_raddr;
   logic [MW-1:0]     meta_wdata, meta_q, meta_rd;
   logic              slot_we;
   logic [SA-1:0]     slot_waddr, slot_raddr;
   logic [IW-1:0]     slot_wdata, slot_q;

   logic [HB-1:0]     rd_head;
   logic [CB-1:0]     rd_cnt;
   logic [KB-1:0]     min_b;
   logic              any_ne;

   function automatic logic [HB-1:0] wrap(input logic [HB-1:0] h, input logic [CB-1:0] o);
      logic [CB:0] s;
      s = (CB + 1)'(h) + (CB + 1)'(o);
      if (s >= (CB + 1)'(CAP)) begin
         s = s - (CB + 1)'(CAP);
      end
      return HB'(s);
   endfunction

   function automatic logic [SA-1:0] slot_addr(input logic [KB-1:0] b, input logic [HB-1:0] p);
      return SA'(b) * SA'(CAP) + SA'(p);
   endfunction

   assign meta_rd = meta_rvld_ff ? meta_q : '0;
   assign rd_head = meta_rd[MW-1:CB];
   assign rd_cnt  = meta_rd[CB-1:0];

   // lowest non-empty bucket
   always_comb begin
      min_b  = '0;
      any_ne = |ne_ff;
      for (int k = NB - 1; k >= 0; k--) begin
         if (ne_ff[k]) begin
            min_b = KB'(k);
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      b_in        = b_ff;
      key_in      = key_ff;
      id_in       = id_ff;
      head_in     = head_ff;
      cnt_in      = cnt_ff;
      i_in        = i_ff;
      ext_in      = ext_ff;
      vld_in      = vld_ff;
      ne_in       = ne_ff;
      total_in    = total_ff;
      rsp_push_in = 1'b0;
      rsp_in      = rsp_ff;
      cmd_take    = 1'b0;
      meta_we     = 1'b0;
      meta_waddr  = b_ff;
      meta_wdata  = '0;
      meta_raddr  = b_ff;
      slot_we     = 1'b0;
      slot_waddr  = slot_addr(b_ff, wrap(head_ff, cnt_ff - CB'(1)));
      slot_wdata  = id_ff;
      slot_raddr  = slot_addr(b_ff, wrap(head_ff, i_ff));

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && !rsp_full && !rsp_push_ff) begin
               cmd_take = 1'b1;
               id_in    = IW'(cmd.item_id);
               key_in   = KB'(cmd.item_key);
               rsp_in   = '{ok: 1'b0, out_id: '0, out_key: '0, now_empty: (total_ff == '0)};
               case (cmd.op)
                  bmpq_pkg::OP_INSERT: begin
                     if (cmd.key_ok) begin
                        b_in       = KB'(cmd.item_key);
                        meta_raddr = KB'(cmd.item_key);
                        state_in   = S_INS;
                     end else begin
                        rsp_push_in = 1'b1;
                     end
                  end
                  bmpq_pkg::OP_EXTRACT, bmpq_pkg::OP_PEEK: begin
                     if (any_ne) begin
                        b_in       = min_b;
                        meta_raddr = min_b;
                        ext_in     = (cmd.op == bmpq_pkg::OP_EXTRACT);
                        state_in   = S_MIN_SLOT;
                     end else begin
                        rsp_push_in = 1'b1;
                     end
                  end
                  bmpq_pkg::OP_DECREASE: begin
                     if (cmd.key_ok) begin
                        b_in     = '0;
                        state_in = S_DK_BKT;
                     end else begin
                        rsp_push_in = 1'b1;
                     end
                  end
                  bmpq_pkg::OP_CLEAR: begin
                     vld_in      = '0;
                     ne_in       = '0;
                     total_in    = '0;
                     rsp_in.ok   = 1'b1;
                     rsp_in.now_empty = 1'b1;
                     rsp_push_in = 1'b1;
                  end
                  default: begin
                     rsp_push_in = 1'b1;
                  end
               endcase
            end
         end

         S_INS: begin
            if (rd_cnt < CB'(CAP)) begin
               slot_we     = 1'b1;
               slot_waddr  = slot_addr(b_ff, wrap(rd_head, rd_cnt));
               meta_we     = 1'b1;
               meta_wdata  = {rd_head, rd_cnt + CB'(1)};
               vld_in[b_ff] = 1'b1;
               ne_in[b_ff]  = 1'b1;
               total_in    = total_ff + TW'(1);
               rsp_in.ok   = 1'b1;
               rsp_in.now_empty = 1'b0;
            end
            rsp_push_in = 1'b1;
            state_in    = S_IDLE;
         end

         S_MIN_SLOT: begin
            head_in    = rd_head;
            cnt_in     = rd_cnt;
            slot_raddr = slot_addr(b_ff, rd_head);
            state_in   = S_MIN_DONE;
         end

         S_MIN_DONE: begin
            rsp_in.ok      = 1'b1;
            rsp_in.out_id  = bmpq_pkg::ID_W'(slot_q);
            rsp_in.out_key = bmpq_pkg::OKEY_W'(b_ff);
            rsp_in.now_empty = 1'b0;
            if (ext_ff) begin
               meta_we      = 1'b1;
               meta_wdata   = {wrap(head_ff, CB'(1)), cnt_ff - CB'(1)};
               vld_in[b_ff] = 1'b1;
               if (cnt_ff == CB'(1)) begin
                  ne_in[b_ff] = 1'b0;
               end
               total_in = total_ff - TW'(1);
               rsp_in.now_empty = (total_ff == TW'(1));
            end
            rsp_push_in = 1'b1;
            state_in    = S_IDLE;
         end

         // scan buckets upward for the first occurrence of the id
         S_DK_BKT: begin
            if (ne_ff[b_ff]) begin
               state_in = S_DK_META;
            end else if (b_ff == KB'(NB - 1)) begin
               rsp_push_in = 1'b1;
               state_in    = S_IDLE;
            end else begin
               b_in = b_ff + KB'(1);
            end
         end

         S_DK_META: begin
            head_in  = rd_head;
            cnt_in   = rd_cnt;
            i_in     = '0;
            state_in = S_DK_RD;
         end

         S_DK_RD: begin
            state_in = S_DK_CMP;
         end

         S_DK_CMP: begin
            if (slot_q == id_ff) begin
               state_in = S_SH_RD;
            end else if (i_ff + CB'(1) == cnt_ff) begin
               if (b_ff == KB'(NB - 1)) begin
                  rsp_push_in = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  b_in     = b_ff + KB'(1);
                  state_in = S_DK_BKT;
               end
            end else begin
               i_in     = i_ff + CB'(1);
               state_in = S_DK_RD;
            end
         end

         // close the gap one slot at a time
         S_SH_RD: begin
            slot_raddr = slot_addr(b_ff, wrap(head_ff, i_ff + CB'(1)));
            if (i_ff + CB'(1) < cnt_ff) begin
               state_in = S_SH_WR;
            end else begin
               state_in = S_DK_PLACE;
            end
         end

         S_SH_WR: begin
            slot_we    = 1'b1;
            slot_waddr = slot_addr(b_ff, wrap(head_ff, i_ff));
            slot_wdata = slot_q;
            i_in       = i_ff + CB'(1);
            state_in   = S_SH_RD;
         end

         S_DK_PLACE: begin
            if (key_ff >= b_ff) begin
               // entry goes back to the tail of its own bucket
               slot_we     = 1'b1;
               rsp_in.ok   = (key_ff == b_ff);
               rsp_push_in = 1'b1;
               state_in    = S_IDLE;
            end else begin
               meta_raddr = key_ff;
               state_in   = S_DK_TGT;
            end
         end

         S_DK_TGT: begin
            slot_we = 1'b1;
            if (rd_cnt >= CB'(CAP)) begin
               rsp_push_in = 1'b1;
               state_in    = S_IDLE;
            end else begin
               slot_waddr     = slot_addr(key_ff, wrap(rd_head, rd_cnt));
               meta_we        = 1'b1;
               meta_waddr     = key_ff;
               meta_wdata     = {rd_head, rd_cnt + CB'(1)};
               vld_in[key_ff] = 1'b1;
               ne_in[key_ff]  = 1'b1;
               state_in       = S_DK_FIX;
            end
         end

         S_DK_FIX: begin
            meta_we      = 1'b1;
            meta_wdata   = {head_ff, cnt_ff - CB'(1)};
            vld_in[b_ff] = 1'b1;
            if (cnt_ff == CB'(1)) begin
               ne_in[b_ff] = 1'b0;
            end
            rsp_in.ok   = 1'b1;
            rsp_push_in = 1'b1;
            state_in    = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         vld_ff      <= '0;
         ne_ff       <= '0;
         total_ff    <= '0;
         rsp_push_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         vld_ff      <= vld_in;
         ne_ff       <= ne_in;
         total_ff    <= total_in;
         rsp_push_ff <= rsp_push_in;
      end
      b_ff         <= b_in;
      key_ff       <= key_in;
      id_ff        <= id_in;
      head_ff      <= head_in;
      cnt_ff       <= cnt_in;
      i_ff         <= i_in;
      ext_ff       <= ext_in;
      rsp_ff       <= rsp_in;
      meta_rvld_ff <= vld_ff[meta_raddr];
   end

   bmpq_ram #(
      .WIDTH(MW),
      .DEPTH(NB)
   ) u_meta_ram (
      .clock(clock),
      .we   (meta_we),
      .waddr(meta_waddr),
      .wdata(meta_wdata),
      .raddr(meta_raddr),
      .rdata(meta_q)
   );

   bmpq_ram #(
      .WIDTH(IW),
      .DEPTH(SD)
   ) u_slot_ram (
      .clock(clock),
      .we   (slot_we),
      .waddr(slot_waddr),
      .wdata(slot_wdata),
      .raddr(slot_raddr),
      .rdata(slot_q)
   );

   assign rsp_push = rsp_push_ff;
   assign rsp      = rsp_ff;

endmodule

/* bench/tb_top.sv */
// self-checking testbench for the bucket min priority queue
class pq_scoreboard;
   bit [15:0]         buckets [128][$];
   int                live_entries;
   bmpq_pkg::rsp_type awaited [$];
   int                errors;
   int                op_count [8];
   int                ok_count;

   function void clear_buckets();
      foreach (buckets[b]) buckets[b].delete();
      live_entries = 0;
   endfunction

   // work out the result of one accepted operation and queue it
   function void note_op(logic [2:0] kind, logic [15:0] id, logic [7:0] key);
      bmpq_pkg::rsp_type r;
      int      fb;
      int      off;
      bit [15:0] moved;
      r = '0;
      op_count[kind]++;
      case (kind)
         bmpq_pkg::KIND_INSERT: begin
            if (key <= 127 && buckets[key].size() < 256) begin
               buckets[key].push_back(id);
               live_entries++;
               r.ok = 1'b1;
            end
         end
         bmpq_pkg::KIND_EXTRACT, bmpq_pkg::KIND_PEEK: begin
            for (int b = 0; b < 128; b++) begin
               if (buckets[b].size() > 0) begin
                  r.ok      = 1'b1;
                  r.out_id  = buckets[b][0];
                  r.out_key = b[6:0];
                  if (kind == bmpq_pkg::KIND_EXTRACT) begin
                     void'(buckets[b].pop_front());
                     live_entries--;
                  end
                  break;
               end
            end
         end
         bmpq_pkg::KIND_DECREASE: begin
            fb = -1;
            off = 0;
            if (key <= 127) begin
               for (int b = 0; b < 128 && fb < 0; b++) begin
                  for (int i = 0; i < buckets[b].size(); i++) begin
                     if (buckets[b][i] == id) begin
                        fb = b;
                        off = i;
                        break;
                     end
                  end
               end
            end
            if (fb >= 0) begin
               moved = buckets[fb][off];
               buckets[fb].delete(off);
               // a higher key or a full target puts the entry back at its old tail
               if (key > fb || buckets[key].size() >= 256) begin
                  buckets[fb].push_back(moved);
               end else begin
                  buckets[key].push_back(moved);
                  r.ok = 1'b1;
               end
            end
         end
         bmpq_pkg::KIND_CLEAR: begin
            clear_buckets();
            r.ok = 1'b1;
         end
         default: ;
      endcase
      r.now_empty = (live_entries == 0);
      if (r.ok) ok_count++;
      awaited.push_back(r);
   endfunction

   function void check_result(bmpq_pkg::rsp_type got);
      bmpq_pkg::rsp_type want;
      if (awaited.size() == 0) begin
         $error("result with nothing outstanding: ok=%0d id=%0h key=%0d empty=%0d",
                got.ok, got.out_id, got.out_key, got.now_empty);
         errors++;
         return;
      end
      want = awaited.pop_front();
      if (got.ok !== want.ok) begin
         $error("ok: expected %0d, got %0d", want.ok, got.ok);
         errors++;
      end
      if (got.out_id !== want.out_id) begin
         $error("out_id: expected %0h, got %0h", want.out_id, got.out_id);
         errors++;
      end
      if (got.out_key !== want.out_key) begin
         $error("out_key: expected %0d, got %0d", want.out_key, got.out_key);
         errors++;
      end
      if (got.now_empty !== want.now_empty) begin
         $error("now_empty: expected %0d, got %0d", want.now_empty, got.now_empty);
         errors++;
      end
   endfunction
endclass

module tb_top;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [2:0]  req_kind = bmpq_pkg::KIND_CLEAR;
   logic [15:0] req_item_id = '0;
   logic [7:0]  req_item_key = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_ok;
   logic [15:0] rsp_out_id;
   logic [6:0]  rsp_out_key;
   logic        rsp_now_empty;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   pq_scoreboard sb = new();

   bucket_min_priority_queue dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver: pop changes at the falling edge, results taken at the rising edge
   always @(negedge clock) begin
      if (!reset) rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         sb.check_result('{rsp_ok, rsp_out_id, rsp_out_key, rsp_now_empty});
   end

   task automatic send_op(logic [2:0] kind, logic [15:0] id, logic [7:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push     = 1'b1;
      req_kind     = kind;
      req_item_id  = id;
      req_item_key = key;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_op(kind, id, key);
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 80) return 8'($urandom_range(15));
      if (r < 90) return 8'($urandom_range(127));
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [15:0] pick_id();
      if ($urandom_range(99) < 80) return 16'($urandom_range(31));
      return 16'($urandom);
   endfunction

   task automatic random_ops(int count);
      int r;
      repeat (count) begin
         r = $urandom_range(99);
         if (r < 40)      send_op(bmpq_pkg::KIND_INSERT, pick_id(), pick_key());
         else if (r < 60) send_op(bmpq_pkg::KIND_EXTRACT, pick_id(), pick_key());
         else if (r < 70) send_op(bmpq_pkg::KIND_PEEK, pick_id(), pick_key());
         else if (r < 92) send_op(bmpq_pkg::KIND_DECREASE, pick_id(), pick_key());
         else if (r < 96) send_op(bmpq_pkg::KIND_CLEAR, pick_id(), pick_key());
         else             send_op(3'($urandom_range(7, 5)), pick_id(), pick_key());
      end
   endtask

   // fill one bucket to capacity, then push and move into it
   task automatic fill_bucket();
      for (int i = 0; i < 256; i++) send_op(bmpq_pkg::KIND_INSERT, 16'(i * 257), 8'd7);
      send_op(bmpq_pkg::KIND_INSERT, 16'h1234, 8'd7);
      send_op(bmpq_pkg::KIND_INSERT, 16'hbeef, 8'd9);
      send_op(bmpq_pkg::KIND_DECREASE, 16'hbeef, 8'd7);
      send_op(bmpq_pkg::KIND_PEEK, 16'h0, 8'd0);
      send_op(bmpq_pkg::KIND_DECREASE, 16'h0101, 8'd2);
      send_op(bmpq_pkg::KIND_EXTRACT, 16'h0, 8'd0);
      send_op(bmpq_pkg::KIND_CLEAR, 16'h0, 8'd0);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_op(bmpq_pkg::KIND_EXTRACT, 16'h0, 8'd0);
      send_op(bmpq_pkg::KIND_PEEK, 16'hffff, 8'hff);
      send_op(bmpq_pkg::KIND_INSERT, 16'h0000, 8'd0);
      send_op(bmpq_pkg::KIND_INSERT, 16'hffff, 8'd127);
      send_op(bmpq_pkg::KIND_INSERT, 16'h5555, 8'd128);
      send_op(bmpq_pkg::KIND_INSERT, 16'haaaa, 8'd255);
      send_op(bmpq_pkg::KIND_PEEK, 16'h0, 8'd0);
      send_op(bmpq_pkg::KIND_EXTRACT, 16'h0, 8'd0);
      send_op(bmpq_pkg::KIND_EXTRACT, 16'h0, 8'd0);
      send_op(bmpq_pkg::KIND_EXTRACT, 16'h0, 8'd0);
      send_op(bmpq_pkg::KIND_DECREASE, 16'h0042, 8'd1);
      send_op(bmpq_pkg::KIND_INSERT, 16'h00a1, 8'd10);
      send_op(bmpq_pkg::KIND_INSERT, 16'h00b2, 8'd10);
      send_op(bmpq_pkg::KIND_DECREASE, 16'h00a1, 8'd200);
      send_op(bmpq_pkg::KIND_DECREASE, 16'h00a1, 8'd10);
      send_op(bmpq_pkg::KIND_DECREASE, 16'h00a1, 8'd20);
      send_op(bmpq_pkg::KIND_DECREASE, 16'h00b2, 8'd3);
      send_op(bmpq_pkg::KIND_PEEK, 16'h0, 8'd0);
      send_op(3'd5, 16'h1, 8'd1);
      send_op(3'd6, 16'h2, 8'd2);
      send_op(3'd7, 16'h3, 8'd3);
      send_op(bmpq_pkg::KIND_EXTRACT, 16'h0, 8'd0);
      send_op(bmpq_pkg::KIND_CLEAR, 16'h0, 8'd0);
      send_op(bmpq_pkg::KIND_EXTRACT, 16'h0, 8'd0);

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1) ? 81 : (phase == 3) ? 27 : 0;
         recv_stall_pct = (phase == 2) ? 81 : (phase == 3) ? 27 : 0;
         if (phase == 0) fill_bucket();
         random_ops(130);
         send_idle_pct  = 0;
         recv_stall_pct = 0;
         random_ops(30);
         send_idle_pct  = (phase == 1) ? 81 : (phase == 3) ? 27 : 0;
         recv_stall_pct = (phase == 2) ? 81 : (phase == 3) ? 27 : 0;
         random_ops(105);
      end
      req_push = 1'b0;
      recv_stall_pct = 0;

      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("ran %0d inserts, %0d extracts, %0d peeks, %0d decreases, %0d clears",
               sb.op_count[bmpq_pkg::KIND_INSERT], sb.op_count[bmpq_pkg::KIND_EXTRACT],
               sb.op_count[bmpq_pkg::KIND_PEEK], sb.op_count[bmpq_pkg::KIND_DECREASE],
               sb.op_count[bmpq_pkg::KIND_CLEAR]);
      $display("%0d transactions succeeded, %0d mismatches", sb.ok_count, sb.errors);
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d results outstanding", sb.awaited.size());
      $display("*** FAILED ***");
      $finish;
   end
endmodule
